### design/dot_perspective_projector_unit_macros.svh
// Assertion helpers shared by dpp_front and dpp_fifo
`ifndef DOT_PERSPECTIVE_PROJECTOR_UNIT_MACROS_SVH
`define DOT_PERSPECTIVE_PROJECTOR_UNIT_MACROS_SVH

// property must hold whenever reset is released
`define DPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked in the following cycle
`define DPP_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

### design/dpp_pkg.sv
package dpp_pkg;

    localparam int CoordBits = 16;
    localparam int DepthBits = 18;          // bp in (-...,  ~41768]; vis_s needs bp > 0
    localparam int DivStages = 35;          // divider stages; quotient bits of the column divider

    localparam logic [1:0] RegSine   = 2'd0;
    localparam logic [1:0] RegCosine = 2'd1;
    localparam logic [1:0] RegFade   = 2'd2;

    // front-end classified item
    typedef struct packed {
        logic               vis_s;
        logic               vis_b;
        logic signed [35:0] s9;      // 9*s
        logic signed [23:0] py64;    // 64*pos_y
        logic [16:0]        bp;      // positive depth
    } front_item_t;

    typedef struct packed {
        logic       shadow_visible;
        logic       ball_visible;
        logic [9:0] screen_col;
        logic [7:0] shadow_row;
        logic [8:0] ball_row;
        logic [7:0] shadow_gray;
        logic [7:0] ball_red;
        logic [7:0] ball_green;
        logic [7:0] ball_blue;
    } result_t;

    // fade with f in 0..1023 and c in 0..255
    function automatic logic [7:0] fade_fn(input logic [7:0] c, input logic [9:0] f);
        logic signed [19:0] r;
        logic [17:0] p;
        begin
            p = 18'(({1'b0, 9'd256} - {2'b0, c}) * {8'b0, f});
            if (f > 10'd256)
                r = 20'sd512 - $signed({10'b0, f});
            else
                r = $signed({12'b0, c}) + $signed({2'b0, p[17:8]});
            if (r < 0)
                fade_fn = 8'd0;
            else if (r > 20'sd255)
                fade_fn = 8'd255;
            else
                fade_fn = r[7:0];
        end
    endfunction

endpackage

### design/dot_perspective_projector_unit.sv
// Pipeline: 2 front stages, 1 queue, 1 load register, 35 divider stages, 1 output.
// Throughput: one dot per cycle when not stalled; the pipelined restoring divider sets the rate.
// Input stalls while the 8-entry queue holds 5 or more; back end stalls only on m_tready.
// Reset: aresetn synchronous active low; clears valids and config registers to 0.
module dot_perspective_projector_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pos_x, pos_y, pos_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // shadow_visible, ball_visible, screen_col, shadow_row,
                                   // ball_row, shadow_gray, ball_red, ball_green, ball_blue
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic signed [15:0] sine_reg, cosine_reg;
    logic [9:0]         fade_reg;
    logic               f_valid, q_af, q_valid, b_ready, m_v;
    dpp_pkg::front_item_t f_item, q_item;
    dpp_pkg::result_t     res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sine_reg   <= '0;
            cosine_reg <= '0;
            fade_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                dpp_pkg::RegSine:   sine_reg   <= cfg_data;
                dpp_pkg::RegCosine: cosine_reg <= cfg_data;
                dpp_pkg::RegFade:   fade_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign s_tready = !q_af;

    dpp_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid && s_tready),
        .pos_x(s_tdata[15:0]), .pos_y(s_tdata[31:16]), .pos_z(s_tdata[47:32]),
        .rot_sine(sine_reg), .rot_cosine(cosine_reg),
        .stall(1'b0),
        .out_valid(f_valid), .out_item(f_item)
    );

    dpp_fifo u_fifo (
        .aclk, .aresetn,
        .wr_en(f_valid), .wr_data(f_item), .almost_full(q_af),
        .rd_en(q_valid && b_ready), .rd_valid(q_valid), .rd_data(q_item)
    );

    dpp_back u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_item(q_item), .in_ready(b_ready),
        .fade_amount(fade_reg),
        .m_valid(m_v), .m_data(res), .m_ready(m_tready)
    );

    assign m_tvalid = m_v;
    assign m_tdata  = {3'b0, res.ball_blue, res.ball_green, res.ball_red, res.shadow_gray,
                       res.ball_row, res.shadow_row, res.screen_col,
                       res.ball_visible, res.shadow_visible};
endmodule

### design/dpp_front.sv
`include "dot_perspective_projector_unit_macros.svh"
module dpp_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic signed [15:0]      pos_x,
    input  logic signed [15:0]      pos_y,
    input  logic signed [15:0]      pos_z,
    input  logic signed [15:0]      rot_sine,
    input  logic signed [15:0]      rot_cosine,
    input  logic                    stall,
    output logic                    out_valid,
    output dpp_pkg::front_item_t    out_item
);
    // stage 1: products
    logic               v1_reg;
    logic signed [31:0] zc_reg, xs_reg, zs_reg, xc_reg;
    logic signed [23:0] py64_reg;
    // stage 2: depth and classification
    logic               v2_reg;
    dpp_pkg::front_item_t it_reg, it_next;

    logic signed [32:0] d, s;
    logic signed [17:0] bp;
    logic signed [35:0] s9;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (!stall) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            zc_reg   <= pos_z * rot_cosine;
            xs_reg   <= pos_x * rot_sine;
            zs_reg   <= pos_z * rot_sine;
            xc_reg   <= pos_x * rot_cosine;
            py64_reg <= 24'(pos_y) <<< 6;
            it_reg   <= it_next;
        end
    end

    always_comb begin
        d  = 33'(zc_reg) - 33'(xs_reg);
        s  = 33'(zs_reg) + 33'(xc_reg);
        bp = 18'(d >>> 16) + 18'sd9000;
        s9 = 36'(s) * 36'sd9;
        it_next.s9   = s9;
        it_next.py64 = py64_reg;
        it_next.bp   = bp[16:0];
        // 159*2048*bp and 99*bp compares
        it_next.vis_s = (bp > 0) && (s9 <= 36'(bp) * 36'sd325632)
                        && (36'sd524288 <= 36'(bp) * 36'sd99);
        it_next.vis_b = it_next.vis_s && (36'(py64_reg) <= 36'(bp) * 36'sd99);
    end

    assign out_valid = v2_reg;
    assign out_item  = it_reg;

    `DPP_ASSERT_NEXT(a_front_hold, stall && v2_reg, v2_reg, "front dropped item in stall")
    `DPP_ASSERT(a_front_ball, !(v2_reg && it_reg.vis_b && !it_reg.vis_s), "ball w/o shadow")
    `DPP_ASSERT(a_front_bp, !(v2_reg && it_reg.vis_s && it_reg.bp == 17'd0), "zero depth")
endmodule

### design/dpp_fifo.sv
`include "dot_perspective_projector_unit_macros.svh"
module dpp_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  dpp_pkg::front_item_t wr_data,
    output logic                 almost_full,
    input  logic                 rd_en,
    output logic                 rd_valid,
    output dpp_pkg::front_item_t rd_data
);
    // depth 8; almost_full leaves room for the 2 in-flight front stages
    dpp_pkg::front_item_t mem_reg [8];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr_en) wp_reg <= wp_reg + 3'd1;
            if (rd_en) rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_reg + 4'(wr_en) - 4'(rd_en);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

    assign rd_valid    = cnt_reg != 4'd0;
    assign rd_data     = mem_reg[rp_reg];
    assign almost_full = cnt_reg >= 4'd5;

    `DPP_ASSERT(a_fifo_ovf, !(cnt_reg == 4'd8 && wr_en && !rd_en), "fifo overflow")
    `DPP_ASSERT(a_fifo_udf, !(cnt_reg == 4'd0 && rd_en), "fifo underflow")
endmodule

### design/dpp_back.sv
module dpp_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  dpp_pkg::front_item_t in_item,
    output logic                 in_ready,
    input  logic [9:0]           fade_amount,
    output logic                 m_valid,
    output dpp_pkg::result_t     m_data,
    input  logic                 m_ready
);
    localparam int N = dpp_pkg::DivStages;
    // numerator magnitudes: |s9| < 2^35, py64, 524288 ; divisor bp
    // restoring dividers, one quotient bit per stage; floor fixed at end
    typedef struct packed {
        logic               vs, vb;
        logic [16:0]        bp;
        logic               sneg, pneg;
        logic [34:0]        sn;   logic [16:0] sr;  // col numerator / rem
        logic [34:0]        sq;
        logic [23:0]        pn;   logic [16:0] pr;
        logic [23:0]        pq;
        logic [19:0]        hn;   logic [16:0] hr;
        logic [19:0]        hq;
        logic signed [18:0] gg, bb, rr;  // green, blue, red before fade
    } dstage_t;

    logic    adv;
    logic    v_reg [N+1];
    dstage_t st_reg [N+1];
    dstage_t st_next [N+1];
    logic    ov_reg;
    dpp_pkg::result_t res_reg, res_next;

    // floor(n/d) by reciprocal: m = ceil(2^24/d), dm1 = d-1; |n| below 2^18
    function automatic logic signed [18:0] div_const(input logic signed [18:0] n,
                                                     input logic [22:0] m,
                                                     input logic [17:0] dm1);
        logic [17:0] a;
        logic [40:0] p;
        begin
            a = (n < 0) ? 18'(-n) + dm1 : 18'(n);
            p = 41'(a) * 41'(m);
            div_const = (n < 0) ? -19'($signed({1'b0, p[40:24]}))
                                : 19'($signed({1'b0, p[40:24]}));
        end
    endfunction

    // colors may be out of 0..255 before fade; exact integer fade
    function automatic logic [7:0] fadex(input logic signed [18:0] c);
        logic signed [31:0] r, p;
        begin
            if (fade_amount > 10'd256)
                r = 32'sd512 - 32'($signed({1'b0, fade_amount}));
            else if (fade_amount != 10'd0) begin
                p = (32'sd256 - 32'(c)) * 32'($signed({1'b0, fade_amount}));
                r = 32'(c) + (p >>> 8);
            end else
                r = 32'(c);
            fadex = (r < 0) ? 8'd0 : (r > 32'sd255) ? 8'd255 : r[7:0];
        end
    endfunction

    assign adv      = !ov_reg || m_ready;
    assign in_ready = adv;

    // stage 0 load
    always_comb begin
        logic [35:0] as9;
        as9 = in_item.s9[35] ? 36'(-in_item.s9) : 36'(in_item.s9);
        st_next[0]      = '0;
        st_next[0].vs   = in_item.vis_s;
        st_next[0].vb   = in_item.vis_b;
        st_next[0].bp   = in_item.bp;
        st_next[0].sneg = in_item.s9[35];
        st_next[0].sn   = as9[34:0];
        st_next[0].pneg = ~in_item.py64[23];   // quotient of -py64
        st_next[0].pn   = in_item.py64[23] ? 24'(-in_item.py64) : in_item.py64;
        st_next[0].hn   = 20'd524288;
    end

    genvar g;
    generate
        for (g = 1; g <= N; g++) begin : g_div
            always_comb begin
                logic [17:0] ts, tp, th;
                st_next[g] = st_reg[g-1];
                ts = '0;
                tp = '0;
                th = '0;
                if (N - g < 35) begin
                    ts = {st_reg[g-1].sr, st_reg[g-1].sn[34]};
                    st_next[g].sn = st_reg[g-1].sn << 1;
                    st_next[g].sq = st_reg[g-1].sq << 1;
                    if (ts >= {1'b0, st_reg[g-1].bp}) begin
                        ts = ts - {1'b0, st_reg[g-1].bp};
                        st_next[g].sq[0] = 1'b1;
                    end
                    st_next[g].sr = ts[16:0];
                end
                if (N - g < 24) begin
                    tp = {st_reg[g-1].pr, st_reg[g-1].pn[23]};
                    st_next[g].pn = st_reg[g-1].pn << 1;
                    st_next[g].pq = st_reg[g-1].pq << 1;
                    if (tp >= {1'b0, st_reg[g-1].bp}) begin
                        tp = tp - {1'b0, st_reg[g-1].bp};
                        st_next[g].pq[0] = 1'b1;
                    end
                    st_next[g].pr = tp[16:0];
                end
                if (N - g < 20) begin
                    th = {st_reg[g-1].hr, st_reg[g-1].hn[19]};
                    st_next[g].hn = st_reg[g-1].hn << 1;
                    st_next[g].hq = st_reg[g-1].hq << 1;
                    if (th >= {1'b0, st_reg[g-1].bp}) begin
                        th = th - {1'b0, st_reg[g-1].bp};
                        st_next[g].hq[0] = 1'b1;
                    end
                    st_next[g].hr = th[16:0];
                end
                // depth shading rides along the first two divider stages
                if (g == 1) begin
                    st_next[g].gg = div_const(19'sd32000
                                    - 19'($signed({1'b0, st_reg[g-1].bp, 1'b0})),
                                    23'd134218, 18'd124);
                end
                if (g == 2) begin
                    st_next[g].bb = div_const(st_reg[g-1].gg * 19'sd11, 23'd1677722, 18'd9);
                    st_next[g].rr = div_const(st_reg[g-1].gg, 23'd5592406, 18'd2);
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= N; i++) v_reg[i] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= N; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i <= N; i++) st_reg[i] <= st_next[i];
        end
    end

    // column divisor is 2048*bp: q = floor(|s9|/bp) then >>11 keeps floor for magnitude
    always_comb begin
        dstage_t t;
        logic signed [36:0] colq, col;
        logic [23:0] cq;
        logic signed [25:0] pq, brow;
        logic signed [20:0] hq, srow;
        t = st_reg[N];
        // floor for negative numerator: -(ceil)
        cq = t.sq[34:11];
        if (t.sneg) begin
            colq = -37'($signed({1'b0, cq}))
                   - 37'((t.sr != 0 || t.sq[10:0] != 0) ? 1 : 0);
        end else begin
            colq = 37'($signed({1'b0, cq}));
        end
        col = colq + 37'sd160;
        if (col < -37'sd512) col = -37'sd512;
        if (t.pneg)
            pq = -26'($signed({1'b0, t.pq})) - 26'((t.pr != 0) ? 1 : 0);
        else
            pq = 26'($signed({1'b0, t.pq}));
        brow = pq + 26'sd100;
        if (brow > 26'sd511) brow = 26'sd511;
        if (brow < 0) brow = 0;
        hq   = -21'($signed({1'b0, t.hq})) - 21'((t.hr != 0) ? 1 : 0);
        srow = hq + 21'sd100;
        res_next = '0;
        if (t.vs) begin
            res_next.shadow_visible = 1'b1;
            res_next.screen_col     = col[9:0];
            res_next.shadow_row     = srow[7:0];
            res_next.shadow_gray    = dpp_pkg::fade_fn(8'd44, fade_amount);
        end
        if (t.vb) begin
            res_next.ball_visible = 1'b1;
            res_next.ball_row     = brow[8:0];
            res_next.ball_red     = fadex(t.rr);
            res_next.ball_green   = fadex(t.gg);
            res_next.ball_blue    = fadex(t.bb);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= v_reg[N];
    end

    always_ff @(posedge aclk) begin
        if (adv) res_reg <= res_next;
    end

    assign m_valid = ov_reg;
    assign m_data  = res_reg;
endmodule
